FILE: rtl/crlf_pkg.sv
// shared widths, character codes and state type for the crlf line assembler
package crlf_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LIMIT_W    = 7;
	localparam int unsigned LINE_LEN_W = 6;
	localparam int unsigned OUT_DATA_W = 16;

	localparam logic [BYTE_W-1:0]  CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0]  CHAR_LF = 8'h0A;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_LOAD = 3'b100
	} asm_state_t;

endpackage

FILE: rtl/crlf_line_assembler_core.sv
// crlf line assembler: gathers received bytes into lines and streams them out
//
// Input stream s_*: one received byte per request in s_tdata[7:0]. CR or LF
// ends a line; a terminator on an empty line is ignored. A data byte that
// arrives when the line store holds LINE_CAPACITY - 1 bytes clears the line
// and is dropped.
// Output stream m_*: one line byte per request, m_tlast on the final byte,
// the line length (after truncation to out_limit - 1) on every byte.
// Config channel cfg_*: writes out_limit (reset value 64); always ready.
// Flow: a data byte is written to the line store as it is accepted. A
// terminator starts a readout of the line store: for each byte the READ
// state reads the memory and the LOAD state loads the output register once
// that register is free, so a receiver stall holds the readout; s_tready
// stays low while the readout runs. The final byte may still wait in the
// output register while the next input is taken.
// Reset: the line is empty and no output is pending; the line store itself
// holds no reset value. A stalled receiver holds the output register and the
// readout waits behind it.
module crlf_line_assembler_core
	import crlf_pkg::*;
#(
	parameter int unsigned LINE_CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] line_byte, [13:8] line_length
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LIMIT_W-1:0]    cfg_data
);

	localparam int unsigned DEPTH  = LINE_CAPACITY - 1;
	localparam int unsigned CNT_W  = $clog2(LINE_CAPACITY);
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	asm_state_t            state_q;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [LIMIT_W-1:0]    out_limit_q;
	logic [BYTE_W-1:0]     mem [DEPTH];
	logic [BYTE_W-1:0]     rdata_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_last_q;
	logic [CNT_W-1:0]      out_len_q;

	logic                  in_acc;
	logic                  is_term;
	logic                  full;
	logic                  wr_en;
	logic                  out_free;
	logic                  rd_last;
	logic [LIMIT_W-1:0]    fill_ext;
	logic [LIMIT_W-1:0]    limit;
	logic [LIMIT_W-1:0]    len_full;
	logic [CNT_W-1:0]      len_new;
	logic [LINE_LEN_W-1:0] out_len_ext;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign is_term   = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign wr_en     = in_acc && !is_term && !full;
	assign out_free  = !out_valid_q || m_tready;
	assign rd_last   = (rd_idx_q == len_q - CNT_W'(1));

	// truncated line length at a terminator
	assign fill_ext = LIMIT_W'(fill_q);
	assign limit    = (out_limit_q < LIMIT_MIN) ? LIMIT_MIN : out_limit_q;
	assign len_full = (fill_ext >= limit) ? (limit - LIMIT_W'(1)) : fill_ext;
	assign len_new  = len_full[CNT_W-1:0];

	// line store, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[ADDR_W-1:0]] <= s_tdata;
		end
		rdata_q <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			out_limit_q <= cfg_data;
		end
	end

	// fill count, readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (is_term) begin
							if (fill_q != '0) begin
								len_q    <= len_new;
								rd_idx_q <= '0;
								fill_q   <= '0;
								state_q  <= ST_READ;
							end
						end else if (full) begin
							fill_q <= '0;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						if (rd_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_LOAD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && out_free) begin
			out_byte_q <= rdata_q;
			out_last_q <= rd_last;
			out_len_q  <= len_q;
		end
	end

	assign out_len_ext = LINE_LEN_W'(out_len_q);
	assign m_tvalid    = out_valid_q;
	assign m_tlast     = out_last_q;
	assign m_tdata     = {{(OUT_DATA_W - BYTE_W - LINE_LEN_W){1'b0}}, out_len_ext, out_byte_q};

endmodule

FILE: tb/tb_top.sv
// testbench for the crlf line assembler core: byte stream in, checked line stream out
`timescale 1ns / 1ps

module tb_top
	import crlf_pkg::*;
();

	localparam int LINE_CAP     = 64;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYC   = 6;
	localparam int END_SETTLE   = 10;

	typedef struct packed {
		logic [BYTE_W-1:0]     line_byte;
		logic                  line_last;
		logic [LINE_LEN_W-1:0] line_length;
	} line_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata;   // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [7:0] line_byte, [13:8] line_length
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [LIMIT_W-1:0]    cfg_data;

	// predictor state: line contents, fill count and current output limit
	logic [BYTE_W-1:0]  line_buf [LINE_CAP-1];
	int                 line_fill;
	logic [LIMIT_W-1:0] line_limit;
	line_beat_t         line_beat_q [$];

	int  errors;
	int  idle_cycles;
	bit  quiet;
	int  bytes_sent;
	int  lines_emitted;
	int  beats_checked;
	int  ignored_terms;
	int  overflow_drops;
	int  limit_writes;

	crlf_line_assembler_core #(
		.LINE_CAPACITY(LINE_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// line assembly: store the byte, or close the line and queue its bytes
	task automatic assemble_rx_byte(input logic [BYTE_W-1:0] b);
		int lim;
		int n;
		line_beat_t beat;
		if (b == CHAR_CR || b == CHAR_LF) begin
			if (line_fill == 0) begin
				ignored_terms++;
			end else begin
				lim = int'(line_limit);
				if (lim < int'(LIMIT_MIN))
					lim = int'(LIMIT_MIN);
				n = line_fill;
				if (n >= lim)
					n = lim - 1;
				if (n > LINE_CAP - 1)
					n = LINE_CAP - 1;
				for (int k = 0; k < n; k++) begin
					beat.line_byte   = line_buf[k];
					beat.line_last   = (k == n - 1);
					beat.line_length = LINE_LEN_W'(n);
					line_beat_q.push_back(beat);
				end
				line_fill = 0;
				lines_emitted++;
			end
		end else if (line_fill < LINE_CAP - 1) begin
			line_buf[line_fill] = b;
			line_fill++;
		end else begin
			// store full: line cleared, byte dropped
			line_fill = 0;
			overflow_drops++;
		end
	endtask

	// receiver ready with random stall bursts
	initial begin : ready_gen
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// output check: compare each accepted line byte with the oldest expectation
	always @(negedge clk) begin
		line_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_beat_q.size() == 0) begin
				$error("unexpected line byte %02h (last %0b length %0d)",
					m_tdata[7:0], m_tlast, m_tdata[13:8]);
				errors++;
			end else begin
				want = line_beat_q.pop_front();
				if (m_tdata[7:0] !== want.line_byte) begin
					$error("line_byte: expected %02h, got %02h", want.line_byte, m_tdata[7:0]);
					errors++;
				end
				if (m_tlast !== want.line_last) begin
					$error("line_last: expected %0b, got %0b", want.line_last, m_tlast);
					errors++;
				end
				if (m_tdata[13:8] !== want.line_length) begin
					$error("line_length: expected %0d, got %0d", want.line_length,
						m_tdata[13:8]);
					errors++;
				end
				beats_checked++;
			end
		end
	end

	// watchdog on cycles without any accepted request
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// send one received byte, with an optional idle burst before it
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		assemble_rx_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [BYTE_W-1:0] text_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
		return b;
	endfunction

	// hold the sender until every queued line byte has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (line_beat_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid  <= 1'b0;
		line_limit = v;
		limit_writes++;
	endtask

	task automatic send_text_line(input int n, input logic [BYTE_W-1:0] term);
		for (int i = 0; i < n; i++)
			send_byte(text_byte());
		send_byte(term);
	endtask

	// byte extremes, terminators on empty lines, codes next to CR and LF
	task automatic test_directed();
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_CR);
		send_byte(8'h0C);
		send_byte(8'h0E);
		send_byte(8'h09);
		send_byte(8'h0B);
		send_byte(CHAR_LF);
		send_byte(CHAR_LF);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
	endtask

	// limits below two, at three and at the top of the register range
	task automatic test_limit_extremes();
		write_limit(7'd0);
		send_text_line(3, CHAR_CR);
		write_limit(7'd1);
		send_text_line(2, CHAR_LF);
		write_limit(7'd3);
		send_text_line(3, CHAR_LF);
		write_limit(7'd127);
		send_text_line(3, CHAR_CR);
	endtask

	// full store emitted whole, then a byte past capacity clears the line
	task automatic test_capacity();
		write_limit(LIMIT_RESET);
		send_text_line(LINE_CAP - 1, CHAR_CR);
		for (int i = 0; i < LINE_CAP; i++)
			send_byte(text_byte());
		send_byte(CHAR_LF);
		send_text_line(1, CHAR_CR);
	endtask

	// random lines with some noise, stray terminators and crlf pairs
	task automatic send_random_lines(input int n_items);
		int start;
		int kind;
		int len;
		logic [BYTE_W-1:0] term;
		start = bytes_sent;
		while (bytes_sent - start < n_items) begin
			kind = $urandom_range(0, 11);
			if (kind == 0) begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (kind == 1) begin
				send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 30)
				                                  : $urandom_range(1, 10);
				term = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
				send_text_line(len, term);
				if ($urandom_range(0, 3) == 0)
					send_byte(CHAR_LF);
				if (!quiet && $urandom_range(0, 9) == 0)
					wait_drained();
			end
		end
	endtask

	task automatic test_random_limits();
		write_limit(7'd5);
		send_random_lines(6);
		write_limit(LIMIT_W'($urandom_range(int'(LIMIT_MIN), 64)));
		send_random_lines(6);
	endtask

	// last stretch without any idling on either side
	task automatic test_full_rate();
		write_limit(LIMIT_W'($urandom_range(8, 20)));
		quiet = 1'b1;
		send_random_lines(8);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		line_fill   = 0;
		line_limit  = LIMIT_RESET;
		errors      = 0;
		idle_cycles = 0;
		quiet       = 1'b0;
		bytes_sent     = 0;
		lines_emitted  = 0;
		beats_checked  = 0;
		ignored_terms  = 0;
		overflow_drops = 0;
		limit_writes   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limit_extremes();
		test_capacity();
		test_random_limits();
		test_full_rate();

		s_tvalid <= 1'b0;
		while (line_beat_q.size() != 0) @(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		$display("sent %0d bytes over %0d limit settings: %0d lines, %0d bytes checked",
			bytes_sent, limit_writes + 1, lines_emitted, beats_checked);
		$display("ignored terminators on empty lines: %0d, capacity overflows: %0d",
			ignored_terms, overflow_drops);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
